@@ rtl/guid_text_parser_top_macros.svh @@
// assertion macros for the guid text parser
// used by guid_text_parser_top; expects signals named clock and reset in scope
`ifndef GUID_TEXT_PARSER_TOP_MACROS_SVH
`define GUID_TEXT_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define GTP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gtp assertion failed");

// next-cycle implication, checked out of reset
`define GTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gtp assertion failed");

`endif

@@ rtl/gtp_pkg.sv @@
// shared types, constants and character-class functions for the guid text parser
// no dependencies; used by the character channel interface, gtp_parser and the top level
package gtp_pkg;

   localparam int CHAR_W = 16;

   // parse phases
   localparam logic [1:0] PH_LEAD  = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_CLOSE = 2'd2;
   localparam logic [1:0] PH_TRAIL = 2'd3;

   // body geometry
   localparam logic [5:0] BODY_LEN   = 6'd36;
   localparam logic [5:0] DASH_POS_A = 6'd8;
   localparam logic [5:0] DASH_POS_B = 6'd13;
   localparam logic [5:0] DASH_POS_C = 6'd18;
   localparam logic [5:0] DASH_POS_D = 6'd23;

   // special characters
   localparam logic [CHAR_W-1:0] CH_DASH   = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_CR     = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;

   // letters a-f / A-F have low nibble 1..6, value is that plus nine
   localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              is_last;
   } gtp_beat_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] first_word;
      logic [15:0] second_half;
      logic [15:0] third_half;
      logic [63:0] tail_bytes;
   } gtp_result_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [5:0] char_count;
   } gtp_status_type;

   function automatic logic is_space_char(logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_hex_char(logic [CHAR_W-1:0] c);
      return c inside {[16'h0030:16'h0039], [16'h0041:16'h0046], [16'h0061:16'h0066]};
   endfunction

   // only meaningful when is_hex_char is true
   function automatic logic [3:0] hex_value(logic [CHAR_W-1:0] c);
      if (c <= CH_NINE) begin
         return c[3:0];
      end
      return c[3:0] + HEX_ALPHA_OFS;
   endfunction

endpackage

@@ rtl/gtp_req_if.sv @@
// character channel for the guid text parser: valid/ready plus one character beat
// depends on gtp_pkg
interface gtp_req_if;
   logic                        valid;
   logic                        ready;
   logic [gtp_pkg::CHAR_W-1:0]  char_code;
   logic                        is_last;

   modport source (output valid, char_code, is_last, input ready);
   modport sink   (input valid, char_code, is_last, output ready);
endinterface

@@ rtl/gtp_rsp_if.sv @@
// result channel for the guid text parser: valid/ready plus the parsed guid parts
// no package dependency
interface gtp_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [31:0] first_word;
   logic [15:0] second_half;
   logic [15:0] third_half;
   logic [63:0] tail_bytes;

   modport source (output valid, valid_res, first_word, second_half, third_half, tail_bytes,
                   input ready);
   modport sink   (input valid, valid_res, first_word, second_half, third_half, tail_bytes,
                   output ready);
endinterface

@@ rtl/guid_text_parser_top.sv @@
// guid text parser top level: input register, parser, result register
// depends on gtp_pkg, gtp_req_if, gtp_rsp_if, gtp_parser and the assertion macros
//
// Usage:
//   req_ch carries one UTF-16 code unit per beat (char_code) with is_last set
//   on the final character of a string. Leading/trailing whitespace and one
//   optional pair of braces around the 8-4-4-4-12 body are accepted.
//   rsp_ch carries one result beat per string, sent for the is_last beat:
//   valid_res plus the four guid parts, all parts zero when the text is invalid.
//   Characters without is_last produce no result beat.
// Result path: an accepted is_last beat passes the input register, then the
//   result register, whose valid flag drives rsp_ch.valid.
// Throughput: one character per cycle, back to back, unless a result is stalled;
//   the parser update is a single character-class decode, counter increment and nibble shift.
// Reset: synchronous, active high; empties both registers and returns the
//   parser to the leading-whitespace phase with cleared accumulators.
// Stall: while rsp_ch.ready is low with a result pending, the pipeline holds;
//   one more character can still be taken into the input register.
`include "guid_text_parser_top_macros.svh"

module guid_text_parser_top (
   input  logic        clock,
   input  logic        reset,
   gtp_req_if.sink     req_ch,
   gtp_rsp_if.source   rsp_ch
);

   logic                    in_vld_ff, in_vld_in;
   gtp_pkg::gtp_beat_type   in_beat_ff, in_beat_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   gtp_pkg::gtp_result_type rsp_ff, rsp_in;

   logic                    adv;
   logic                    step;
   logic                    req_accept;
   gtp_pkg::gtp_result_type parse_result;
   gtp_pkg::gtp_status_type status;

   logic                    rsp_parts_zero;
   logic                    last_step;
   logic                    parser_fresh;
   logic                    in_body;
   logic                    in_held;

   // pipeline advances whenever the result slot is free or being drained
   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign step         = in_vld_ff && adv;
   assign req_ch.ready = !in_vld_ff || adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // input register
   always_comb begin
      in_beat_in = in_beat_ff;
      if (req_accept) begin
         in_vld_in            = 1'b1;
         in_beat_in.char_code = req_ch.char_code;
         in_beat_in.is_last   = req_ch.is_last;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   gtp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (in_beat_ff),
      .result (parse_result),
      .status (status)
   );

   // result register, loaded by the final character of a string
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (adv) begin
         rsp_vld_in = in_vld_ff && in_beat_ff.is_last;
         if (in_vld_ff && in_beat_ff.is_last) begin
            rsp_in = parse_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
      rsp_ff     <= rsp_in;
   end

   // result beat
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.valid_res   = rsp_ff.valid_res;
   assign rsp_ch.first_word  = rsp_ff.first_word;
   assign rsp_ch.second_half = rsp_ff.second_half;
   assign rsp_ch.third_half  = rsp_ff.third_half;
   assign rsp_ch.tail_bytes  = rsp_ff.tail_bytes;

   // terms for the checks
   assign rsp_parts_zero = (rsp_ff.first_word == 32'd0) && (rsp_ff.second_half == 16'd0)
                           && (rsp_ff.third_half == 16'd0) && (rsp_ff.tail_bytes == 64'd0);
   assign last_step      = step && in_beat_ff.is_last;
   assign parser_fresh   = (status.phase == gtp_pkg::PH_LEAD) && (status.char_count == 6'd0);
   assign in_body        = status.phase == gtp_pkg::PH_BODY;
   assign in_held        = in_vld_ff && !adv;

   // checks
   `GTP_ASSERT_IMPL(a_zero_when_invalid, rsp_vld_ff && !rsp_ff.valid_res, rsp_parts_zero)
   `GTP_ASSERT_NEXT(a_fresh_after_last, last_step, parser_fresh)
   `GTP_ASSERT_IMPL(a_body_count_range, in_body, status.char_count < gtp_pkg::BODY_LEN)
   `GTP_ASSERT_NEXT(a_input_held_on_stall, in_held, in_vld_ff && in_beat_ff == $past(in_beat_ff))

endmodule

@@ rtl/gtp_parser.sv @@
// parse state machine and digit accumulators; one character per step
// depends on gtp_pkg
module gtp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  gtp_pkg::gtp_beat_type   beat,
   output gtp_pkg::gtp_result_type result,
   output gtp_pkg::gtp_status_type status
);

   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  char_count_ff, char_count_in;
   logic        brace_seen_ff, brace_seen_in;
   logic        failed_ff, failed_in;
   logic [31:0] first_acc_ff, first_acc_in;
   logic [15:0] second_acc_ff, second_acc_in;
   logic [15:0] third_acc_ff, third_acc_in;
   logic [63:0] tail_acc_ff, tail_acc_in;

   logic        take_body;
   logic        space_char;
   logic        hex_char;
   logic [3:0]  digit;
   logic        dash_pos;
   logic [5:0]  count_inc;
   logic [1:0]  body_phase;
   logic        ok;

   // character classes and body position
   always_comb begin
      space_char = gtp_pkg::is_space_char(beat.char_code);
      hex_char   = gtp_pkg::is_hex_char(beat.char_code);
      digit      = gtp_pkg::hex_value(beat.char_code);
      dash_pos   = char_count_ff inside {gtp_pkg::DASH_POS_A, gtp_pkg::DASH_POS_B,
                                         gtp_pkg::DASH_POS_C, gtp_pkg::DASH_POS_D};
      count_inc  = char_count_ff + 6'd1;
      if (count_inc >= gtp_pkg::BODY_LEN) begin
         body_phase = brace_seen_ff ? gtp_pkg::PH_CLOSE : gtp_pkg::PH_TRAIL;
      end else begin
         body_phase = gtp_pkg::PH_BODY;
      end
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      char_count_in = char_count_ff;
      brace_seen_in = brace_seen_ff;
      failed_in     = failed_ff;
      first_acc_in  = first_acc_ff;
      second_acc_in = second_acc_ff;
      third_acc_in  = third_acc_ff;
      tail_acc_in   = tail_acc_ff;
      take_body     = 1'b0;

      if (step && !failed_ff) begin
         case (phase_ff)
            gtp_pkg::PH_LEAD: begin
               if (!space_char) begin
                  phase_in = gtp_pkg::PH_BODY;
                  if (beat.char_code == gtp_pkg::CH_LBRACE) begin
                     brace_seen_in = 1'b1;
                  end else begin
                     take_body = 1'b1;
                  end
               end
            end
            gtp_pkg::PH_BODY: begin
               take_body = 1'b1;
            end
            gtp_pkg::PH_CLOSE: begin
               if (beat.char_code == gtp_pkg::CH_RBRACE) begin
                  phase_in = gtp_pkg::PH_TRAIL;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               if (!space_char) begin
                  failed_in = 1'b1;
               end
            end
         endcase
      end

      // one body character: hyphen check or nibble shift into the current group
      if (take_body) begin
         if (dash_pos) begin
            if (beat.char_code != gtp_pkg::CH_DASH) begin
               failed_in = 1'b1;
            end
         end else if (!hex_char) begin
            failed_in = 1'b1;
         end else if (char_count_ff < gtp_pkg::DASH_POS_A) begin
            first_acc_in = {first_acc_ff[27:0], digit};
         end else if (char_count_ff < gtp_pkg::DASH_POS_B) begin
            second_acc_in = {second_acc_ff[11:0], digit};
         end else if (char_count_ff < gtp_pkg::DASH_POS_C) begin
            third_acc_in = {third_acc_ff[11:0], digit};
         end else begin
            tail_acc_in = {tail_acc_ff[59:0], digit};
         end
         char_count_in = count_inc;
         phase_in      = body_phase;
      end

      // result reflects the state after this character
      ok                 = !failed_in && (phase_in == gtp_pkg::PH_TRAIL);
      result.valid_res   = ok;
      result.first_word  = ok ? first_acc_in  : 32'd0;
      result.second_half = ok ? second_acc_in : 16'd0;
      result.third_half  = ok ? third_acc_in  : 16'd0;
      result.tail_bytes  = ok ? tail_acc_in   : 64'd0;

      // final character starts a fresh string
      if (step && beat.is_last) begin
         phase_in      = gtp_pkg::PH_LEAD;
         char_count_in = 6'd0;
         brace_seen_in = 1'b0;
         failed_in     = 1'b0;
         first_acc_in  = 32'd0;
         second_acc_in = 16'd0;
         third_acc_in  = 16'd0;
         tail_acc_in   = 64'd0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= gtp_pkg::PH_LEAD;
         char_count_ff <= 6'd0;
         brace_seen_ff <= 1'b0;
         failed_ff     <= 1'b0;
         first_acc_ff  <= 32'd0;
         second_acc_ff <= 16'd0;
         third_acc_ff  <= 16'd0;
         tail_acc_ff   <= 64'd0;
      end else begin
         phase_ff      <= phase_in;
         char_count_ff <= char_count_in;
         brace_seen_ff <= brace_seen_in;
         failed_ff     <= failed_in;
         first_acc_ff  <= first_acc_in;
         second_acc_ff <= second_acc_in;
         third_acc_ff  <= third_acc_in;
         tail_acc_ff   <= tail_acc_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.char_count = char_count_ff;

endmodule

@@ verif/guid_text_parser_top_tb.sv @@
// self-checking bench for guid_text_parser_top: short directed strings, then random
// well-formed, mutated and noise strings. Depends on gtp_pkg, gtp_req_if, gtp_rsp_if.
module guid_text_parser_top_tb;

   typedef logic [gtp_pkg::CHAR_W-1:0] code_type;
   typedef code_type text_type [$];

   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 20;
   localparam int RANDOM_CHARS  = 1350;
   localparam int RANDOM_TEXTS  = 48;

   logic clock;
   logic reset;

   gtp_req_if req_ch ();
   gtp_rsp_if rsp_ch ();

   guid_text_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gtp_pkg::gtp_beat_type   pending_beats  [$];
   gtp_pkg::gtp_result_type expected_guids [$];

   int errors       = 0;
   int results_seen = 0;
   int good_guids   = 0;
   int texts_sent   = 0;
   int chars_sent   = 0;
   int cycle_count  = 0;
   int stall_cycles = 0;
   logic quiet;

   // shadow parser state
   logic [1:0]  prs_phase;
   logic [5:0]  prs_count;
   logic        prs_brace;
   logic        prs_failed;
   logic [31:0] acc_first;
   logic [15:0] acc_second;
   logic [15:0] acc_third;
   logic [63:0] acc_tail;

   // stretch with no idling on either side
   assign quiet = (cycle_count >= 700) && (cycle_count < 1300);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_error(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s got %h want %h", name, got, want));
   endtask

   // ---------------------------------------------------------------- prediction

   task automatic clear_parse();
      prs_phase  = gtp_pkg::PH_LEAD;
      prs_count  = '0;
      prs_brace  = 1'b0;
      prs_failed = 1'b0;
      acc_first  = '0;
      acc_second = '0;
      acc_third  = '0;
      acc_tail   = '0;
   endtask

   function automatic logic blank_char(code_type c);
      return (c == gtp_pkg::CH_SPACE) || (c >= gtp_pkg::CH_TAB && c <= gtp_pkg::CH_CR);
   endfunction

   // -1 for anything that is not a hex digit
   function automatic int nibble_of(code_type c);
      if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
      if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h57;
      if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h37;
      return -1;
   endfunction

   task automatic take_body(code_type c);
      logic [5:0] p;
      int         v;
      logic [3:0] nib;
      p = prs_count;
      v = nibble_of(c);
      nib = v[3:0];
      if (p == gtp_pkg::DASH_POS_A || p == gtp_pkg::DASH_POS_B ||
          p == gtp_pkg::DASH_POS_C || p == gtp_pkg::DASH_POS_D) begin
         if (c != gtp_pkg::CH_DASH) prs_failed = 1'b1;
      end else if (v < 0) begin
         prs_failed = 1'b1;
      end else if (p < gtp_pkg::DASH_POS_A) begin
         acc_first = {acc_first[27:0], nib};
      end else if (p < gtp_pkg::DASH_POS_B) begin
         acc_second = {acc_second[11:0], nib};
      end else if (p < gtp_pkg::DASH_POS_C) begin
         acc_third = {acc_third[11:0], nib};
      end else begin
         acc_tail = {acc_tail[59:0], nib};
      end
      prs_count = p + 6'd1;
      if (prs_count >= gtp_pkg::BODY_LEN)
         prs_phase = prs_brace ? gtp_pkg::PH_CLOSE : gtp_pkg::PH_TRAIL;
   endtask

   task automatic predict_char(gtp_pkg::gtp_beat_type b);
      gtp_pkg::gtp_result_type r;
      if (!prs_failed) begin
         case (prs_phase)
            gtp_pkg::PH_LEAD: begin
               if (!blank_char(b.char_code)) begin
                  prs_phase = gtp_pkg::PH_BODY;
                  if (b.char_code == gtp_pkg::CH_LBRACE) prs_brace = 1'b1;
                  else take_body(b.char_code);
               end
            end
            gtp_pkg::PH_BODY: take_body(b.char_code);
            gtp_pkg::PH_CLOSE: begin
               if (b.char_code == gtp_pkg::CH_RBRACE) prs_phase = gtp_pkg::PH_TRAIL;
               else prs_failed = 1'b1;
            end
            default: begin
               if (!blank_char(b.char_code)) prs_failed = 1'b1;
            end
         endcase
      end
      if (b.is_last) begin
         r = '0;
         if (!prs_failed && prs_phase == gtp_pkg::PH_TRAIL) begin
            r.valid_res   = 1'b1;
            r.first_word  = acc_first;
            r.second_half = acc_second;
            r.third_half  = acc_third;
            r.tail_bytes  = acc_tail;
         end
         expected_guids.push_back(r);
         clear_parse();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic code_type hex_char(int v);
      if (v < 10) return code_type'('h30 + v);
      if ($urandom_range(0, 1) == 0) return code_type'('h57 + v);
      return code_type'('h37 + v);
   endfunction

   function automatic code_type blank_code();
      if ($urandom_range(0, 5) == 0) return gtp_pkg::CH_SPACE;
      return gtp_pkg::CH_TAB + code_type'($urandom_range(0, 4));
   endfunction

   // any character class, weighted toward the interesting ones
   function automatic code_type rand_code();
      code_type edges [12] = '{16'h0008, 16'h000E, 16'h001F, 16'h0021, 16'h002F,
                               16'h003A, 16'h0040, 16'h0047, 16'h0060, 16'h0067,
                               16'h007C, 16'hFFFF};
      case ($urandom_range(0, 7))
         0:       return hex_char($urandom_range(0, 15));
         1:       return gtp_pkg::CH_DASH;
         2:       return $urandom_range(0, 1) ? gtp_pkg::CH_LBRACE : gtp_pkg::CH_RBRACE;
         3:       return blank_code();
         4:       return edges[4'($urandom_range(0, 11))];
         default: return code_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic enqueue_text(text_type t);
      gtp_pkg::gtp_beat_type b;
      foreach (t[i]) begin
         b.char_code = t[i];
         b.is_last   = (i == t.size() - 1);
         pending_beats.push_back(b);
      end
      if (t.size() != 0) texts_sent++;
      chars_sent += t.size();
   endtask

   task automatic enqueue_one(code_type c);
      text_type t;
      t.push_back(c);
      enqueue_text(t);
   endtask

   // guid text, random digits, case, whitespace, braces; well-formed but for mode 9
   task automatic build_guid(output text_type t);
      int mode;
      t = {};
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(0, 2)) t.push_back(blank_code());
      if ((mode >= 6 && mode <= 8) || (mode == 9 && $urandom_range(0, 1) == 0))
         t.push_back(gtp_pkg::CH_LBRACE);
      for (int p = 0; p < int'(gtp_pkg::BODY_LEN); p++) begin
         if (p == gtp_pkg::DASH_POS_A || p == gtp_pkg::DASH_POS_B ||
             p == gtp_pkg::DASH_POS_C || p == gtp_pkg::DASH_POS_D)
            t.push_back(gtp_pkg::CH_DASH);
         else
            t.push_back(hex_char($urandom_range(0, 15)));
      end
      if ((mode >= 6 && mode <= 8) || (mode == 9 && t[0] != gtp_pkg::CH_LBRACE
          && t.size() > 0 && !(t.size() > 1 && t[1] == gtp_pkg::CH_LBRACE)
          && !(t.size() > 2 && t[2] == gtp_pkg::CH_LBRACE)))
         t.push_back(gtp_pkg::CH_RBRACE);
      repeat ($urandom_range(0, 2)) t.push_back(blank_code());
   endtask

   // damage about half of the guids: substitute, cut short, insert, drop, trail text
   task automatic mutate_guid(ref text_type t);
      int pos;
      pos = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 9))
         5: t[pos] = rand_code();
         6: t = t[0:pos];
         7: t.insert(pos, rand_code());
         8: if (t.size() > 1) t.delete(pos);
         9: begin
            t.push_back(blank_code());
            t.push_back(rand_code());
         end
         default: ;
      endcase
   endtask

   // sender holds back until the block has answered everything
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_ch.valid || expected_guids.size() != 0);
   endtask

   initial begin : run_stimulus
      text_type t;
      code_type near_miss [8];
      int       rnd_chars;
      int       rnd_texts;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: whitespace only, lone braces, extreme codes, near-miss characters
      t = {gtp_pkg::CH_SPACE, gtp_pkg::CH_TAB, 16'h000A, 16'h000B, 16'h000C, gtp_pkg::CH_CR};
      enqueue_text(t);
      enqueue_one(gtp_pkg::CH_RBRACE);
      enqueue_one(gtp_pkg::CH_LBRACE);
      enqueue_one(16'hFFFF);
      enqueue_one(16'h0000);
      enqueue_one(gtp_pkg::CH_DASH);
      near_miss = '{16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060, 16'h0067,
                    16'h0008, 16'h000E};
      foreach (near_miss[i])
         enqueue_one(near_miss[i]);
      t = {gtp_pkg::CH_SPACE, gtp_pkg::CH_LBRACE, gtp_pkg::CH_SPACE};
      enqueue_text(t);
      wait_drained();

      // random: mostly guid-shaped strings, some short noise
      rnd_chars = 0;
      rnd_texts = 0;
      while (rnd_chars < RANDOM_CHARS || rnd_texts < RANDOM_TEXTS) begin
         if ($urandom_range(0, 9) < 7) begin
            build_guid(t);
            mutate_guid(t);
         end else begin
            t = {};
            repeat ($urandom_range(1, 6)) t.push_back(rand_code());
         end
         enqueue_text(t);
         rnd_chars += t.size();
         rnd_texts++;
         if (rnd_texts == RANDOM_TEXTS / 2) wait_drained();
      end
      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d strings, %0d characters; %0d results, %0d valid guids",
               texts_sent, chars_sent, results_seen, good_guids);
      if (errors == 0)
         $display("PASS guid_text_parser_top");
      else
         $display("FAIL guid_text_parser_top");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_chars
      gtp_pkg::gtp_beat_type b;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.char_code <= '0;
         req_ch.is_last   <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_beats.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
            b = pending_beats.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.char_code <= b.char_code;
            req_ch.is_last   <= b.is_last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result ready, with one long hold-off once results are flowing
   always @(posedge clock) begin : drive_ready
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // every accepted character beat advances the shadow parser
   always @(posedge clock) begin : watch_chars
      gtp_pkg::gtp_beat_type seen;
      if (reset) begin
         clear_parse();
      end else if (req_ch.valid && req_ch.ready) begin
         seen.char_code = req_ch.char_code;
         seen.is_last   = req_ch.is_last;
         predict_char(seen);
      end
   end

   always @(posedge clock) begin : check_results
      gtp_pkg::gtp_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen <= results_seen + 1;
         if (expected_guids.size() == 0) begin
            report_error("result beat with no string pending");
         end else begin
            want = expected_guids.pop_front();
            check_field("valid_res", 64'(rsp_ch.valid_res), 64'(want.valid_res));
            check_field("first_word", 64'(rsp_ch.first_word), 64'(want.first_word));
            check_field("second_half", 64'(rsp_ch.second_half), 64'(want.second_half));
            check_field("third_half", 64'(rsp_ch.third_half), 64'(want.third_half));
            check_field("tail_bytes", rsp_ch.tail_bytes, want.tail_bytes);
            if (want.valid_res) good_guids <= good_guids + 1;
         end
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("no beat accepted for %0d cycles", stall_cycles);
         $display("FAIL guid_text_parser_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gtp_pkg.sv
rtl/gtp_req_if.sv
rtl/gtp_rsp_if.sv
rtl/gtp_parser.sv
rtl/guid_text_parser_top.sv
verif/guid_text_parser_top_tb.sv
